[rtl/bee_pkg.sv]
// Package for the binary edge extraction unit.
// Holds the shared sizes, register index codes and the item record passed
// from the front end through the queue to the back end. No dependencies.
package bee_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int DimW       = 11;
  localparam int CmpW       = ((ColW > DimW) ? ColW : DimW) + 1;
  localparam int PixW       = 8;
  localparam int SumW       = PixW + 2;
  localparam int QueueDepth = 2;

  localparam logic [DimW-1:0] WidthReset     = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightReset    = DimW'(MaxHeight);
  localparam logic [PixW-1:0] ThresholdReset = 8'd128;
  localparam logic [PixW-1:0] PixBlack       = 8'd0;
  localparam logic [PixW-1:0] PixWhite       = 8'd255;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DARK_THRESHOLD = 2'd2
  } bee_reg_e;

  // One classified pixel: its binary value, position and boundary flags.
  typedef struct packed {
    logic            cur;
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            has_prev;
    logic            interior;
    logic            last_row;
    logic            last_col;
    logic            first_col;
  } bee_item_t;

endpackage

[rtl/bee_front.sv]
// Front end of the binary edge extraction unit: configuration registers,
// pixel thresholding and raster position tracking. Depends on bee_pkg.
module bee_front import bee_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [DimW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output bee_item_t       q_item_o
);

  logic [DimW-1:0] width_q, height_q;
  logic [PixW-1:0] thr_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [DimW-1:0] w_c, h_c;
  logic [CmpW-1:0] w_x, h_x, c0, r0, c1, r1;
  logic [SumW-1:0] sum, thr3;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thr_q    <= ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (bee_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:    width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT:   height_q <= cfg_wdata_i;
        REG_DARK_THRESHOLD: thr_q    <= cfg_wdata_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Dimensions outside their range are clamped to one or to the maximum.
    w_c = width_q;
    if (width_q == '0) begin
      w_c = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_c = DimW'(MaxWidth);
    end
    h_c = height_q;
    if (height_q == '0) begin
      h_c = DimW'(1);
    end else if (height_q > DimW'(MaxHeight)) begin
      h_c = DimW'(MaxHeight);
    end
    w_x = CmpW'(w_c);
    h_x = CmpW'(h_c);

    // A counter left beyond a shrunken frame wraps before it is used.
    c0 = CmpW'(col_q);
    r0 = CmpW'(row_q);
    if (c0 >= w_x) begin
      c0 = '0;
      r0 = r0 + CmpW'(1);
    end
    if (r0 >= h_x) begin
      r0 = '0;
    end

    c1 = c0 + CmpW'(1);
    r1 = r0;
    if (c1 >= w_x) begin
      c1 = '0;
      r1 = r0 + CmpW'(1);
      if (r1 >= h_x) begin
        r1 = '0;
      end
    end
    col_d = c1[ColW-1:0];
    row_d = r1[RowW-1:0];

    sum  = SumW'(red_i) + SumW'(green_i) + SumW'(blue_i);
    thr3 = SumW'(thr_q) + {SumW'(thr_q) << 1};

    q_item_o.cur       = (sum < thr3);
    q_item_o.x         = c0[ColW-1:0];
    q_item_o.y         = r0[RowW-1:0];
    q_item_o.has_prev  = (r0 != '0);
    q_item_o.interior  = (c0 != '0) && ((c0 + CmpW'(1)) < w_x) && (r0 >= CmpW'(2));
    q_item_o.last_row  = ((r0 + CmpW'(1)) == h_x);
    q_item_o.last_col  = ((c0 + CmpW'(1)) == w_x);
    q_item_o.first_col = (c0 == '0);
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/bee_fifo.sv]
// Short queue of classified pixels between the front and back ends.
// Depends on bee_pkg for the item record and the queue depth.
module bee_fifo import bee_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bee_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output bee_item_t item_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  bee_item_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/bee_back.sv]
// Back end of the binary edge extraction unit: the two line buffers, the
// neighborhood check and the output register. Depends on bee_pkg.
module bee_back import bee_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  bee_item_t       q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pixel_value_o,
  output logic [ColW-1:0] out_column_o,
  output logic [RowW-1:0] out_row_o,
  output logic            frame_done_o
);

  logic prev_mem [MaxWidth];
  logic sp_mem   [MaxWidth];

  bee_item_t       e_item_q;
  logic            e_valid_q, sent_q;
  logic [1:0]      left_q;
  logic            mid_raw_q, right_raw_q, up_raw_q;
  logic            fwd_mid_q, fwd_right_q, fwd_up_q, fcur_q, fmid_q;

  logic            out_valid_q, out_done_q;
  logic [PixW-1:0] out_pix_q;
  logic [ColW-1:0] out_col_q;
  logic [RowW-1:0] out_row_q;

  logic            mid_e, right_e, up_e, left_e, clear_e, res_e;
  logic            have_a, emit, is_last, out_slot, push, e_done, e_load;
  logic            res_dark;
  logic [ColW-1:0] x_next;
  logic [1:0]      left_base;

  always_comb begin
    // The item retiring in the same cycle has not yet reached the buffers.
    mid_e   = fwd_mid_q   ? fcur_q : mid_raw_q;
    right_e = fwd_right_q ? fcur_q : right_raw_q;
    up_e    = fwd_up_q    ? fmid_q : up_raw_q;
    left_e  = e_item_q.first_col ? 1'b0 : left_q[0];
    clear_e = e_item_q.interior & mid_e & left_e & right_e & up_e & e_item_q.cur;
    res_e   = mid_e & ~clear_e;

    // The result of the row above goes first, then the pixel's own in the last row.
    have_a   = e_item_q.has_prev & ~sent_q;
    emit     = have_a | e_item_q.last_row;
    is_last  = ~(have_a & e_item_q.last_row);
    out_slot = ~out_valid_q | out_ready_i;
    push     = e_valid_q & emit & out_slot;
    e_done   = e_valid_q & (~emit | (is_last & out_slot));
    e_load   = ~q_empty_i & (~e_valid_q | e_done);
    res_dark = have_a ? res_e : e_item_q.cur;

    x_next    = q_item_i.x + ColW'(1);
    left_base = e_item_q.first_col ? 2'b00 : left_q;
  end

  assign q_pop_o = e_load;

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      mid_raw_q   <= prev_mem[q_item_i.x];
      right_raw_q <= prev_mem[x_next];
    end
    if (e_done) begin
      prev_mem[e_item_q.x] <= e_item_q.cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      up_raw_q <= sp_mem[q_item_i.x];
    end
    if (e_done && e_item_q.has_prev) begin
      sp_mem[e_item_q.x] <= mid_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      e_item_q    <= q_item_i;
      fwd_mid_q   <= e_valid_q && (e_item_q.x == q_item_i.x);
      fwd_right_q <= e_valid_q &&
                     ({1'b0, e_item_q.x} == ({1'b0, q_item_i.x} + (ColW + 1)'(1)));
      fwd_up_q    <= e_valid_q && e_item_q.has_prev && (e_item_q.x == q_item_i.x);
      fcur_q      <= e_item_q.cur;
      fmid_q      <= mid_e;
    end
    if (push) begin
      out_pix_q  <= res_dark ? PixBlack : PixWhite;
      out_col_q  <= e_item_q.x;
      out_row_q  <= have_a ? (e_item_q.y - RowW'(1)) : e_item_q.y;
      out_done_q <= ~have_a & e_item_q.last_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      sent_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (e_load) begin
        e_valid_q <= 1'b1;
      end else if (e_done) begin
        e_valid_q <= 1'b0;
      end
      if (e_done) begin
        sent_q <= 1'b0;
      end else if (push) begin
        sent_q <= 1'b1;
      end
      if (e_done) begin
        left_q <= e_item_q.has_prev ? {left_base[0], mid_e} : left_base;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pix_q;
  assign out_column_o  = out_col_q;
  assign out_row_o     = out_row_q;
  assign frame_done_o  = out_done_q;

endmodule

[rtl/binary_edge_extract_unit.sv]
// Top level of the binary edge extraction unit.
// Instantiates bee_front, bee_fifo and bee_back; depends on bee_pkg.

// Takes RGB pixels in raster order, one transfer per clock while in_ready_o
// is high, thresholds each against the average of its channels and clears
// dark pixels whose four neighbors are all dark, so only region boundaries
// stay dark. The result for pixel (x, y-1) leaves when pixel (x, y) is taken;
// the first row gives no results unless it is also the last, and in the last
// row each pixel also gives its own result, with frame_done set on the frame's
// final one. Outside the last row the unit sustains one pixel per cycle while
// the output is not stalled; in the last row of a frame taller than one row
// each pixel yields two results over the single output port and holds the
// back end until both have left. A result is registered in turn in the queue
// slot, the line buffer read and the output register, and can stall at each.
// The line buffers need no clearing after reset. Write frame_width,
// frame_height and dark_threshold only while the unit is idle.
module binary_edge_extract_unit import bee_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [DimW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pixel_value_o,
  output logic [ColW-1:0] out_column_o,
  output logic [RowW-1:0] out_row_o,
  output logic            frame_done_o
);

  bee_item_t push_item, pop_item;
  logic      q_push, q_full, q_pop, q_empty;

  bee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  bee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  bee_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .frame_done_o  (frame_done_o)
  );

endmodule
